// ===== sv/p3d_pkg.sv =====
// Package: widths, types and register indexes for the periodic 3D distance block.
package p3d_pkg;
  localparam int CoordW = 20;
  localparam int BoxW = 20;
  localparam int DiffW = 22;
  localparam int SqW = 42;
  localparam int OutW = 42;
  localparam int RootW = 21;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 20;

  localparam logic [CfgIdxW-1:0] RegBoxWidth = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBoxHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBoxDepth = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPeriodic = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTakeRoot = 3'd4;

  typedef struct packed {
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
    logic signed [CoordW-1:0] first_z;
    logic signed [CoordW-1:0] second_x;
    logic signed [CoordW-1:0] second_y;
    logic signed [CoordW-1:0] second_z;
  } pair_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

  typedef struct packed {
    logic periodic;
    logic take_root;
  } mode_t;
endpackage

// ===== sv/p3d_if.sv =====
// Interfaces: valid/ready stream channel with a typed payload.
interface p3d_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/p3d_lane.sv =====
// One axis lane: difference, three candidate squares, minimum in periodic mode.
module p3d_lane (
  input  logic clk,
  input  logic en,
  input  logic signed [p3d_pkg::CoordW-1:0] a,
  input  logic signed [p3d_pkg::CoordW-1:0] b,
  input  logic [p3d_pkg::BoxW-1:0] box,
  input  logic periodic,
  output logic [p3d_pkg::SqW-1:0] sq
);
  logic signed [p3d_pkg::DiffW-1:0] d, dlo, dhi;
  logic [p3d_pkg::DiffW-1:0] m0, m1, m2;
  logic [p3d_pkg::DiffW-1:0] m0_r, m1_r, m2_r;
  logic per_r;
  logic [p3d_pkg::SqW-1:0] s0, s1, s2, s0_r, s1_r, s2_r, best;
  logic per_r2;

  always_comb begin
    d = p3d_pkg::DiffW'(a) - p3d_pkg::DiffW'(b);
    dlo = d - $signed({2'b00, box});
    dhi = d + $signed({2'b00, box});
    m0 = d[p3d_pkg::DiffW-1] ? p3d_pkg::DiffW'(-d) : d;
    m1 = dlo[p3d_pkg::DiffW-1] ? p3d_pkg::DiffW'(-dlo) : dlo;
    m2 = dhi[p3d_pkg::DiffW-1] ? p3d_pkg::DiffW'(-dhi) : dhi;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r <= m0;
      m1_r <= m1;
      m2_r <= m2;
      per_r <= periodic;
    end
  end

  always_comb begin
    s0 = p3d_pkg::SqW'({20'd0, m0_r} * {20'd0, m0_r});
    s1 = p3d_pkg::SqW'({20'd0, m1_r} * {20'd0, m1_r});
    s2 = p3d_pkg::SqW'({20'd0, m2_r} * {20'd0, m2_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0;
      s1_r <= s1;
      s2_r <= s2;
      per_r2 <= per_r;
    end
  end

  always_comb begin
    best = s0_r;
    if (per_r2) begin
      if (s1_r < best) best = s1_r;
      if (s2_r < best) best = s2_r;
    end
    sq = best;
  end
endmodule

// ===== sv/p3d_sqrt.sv =====
// Pipelined integer square root, one result bit per stage; passes val through when root is low.
module p3d_sqrt (
  input  logic clk,
  input  logic en,
  input  logic [p3d_pkg::OutW-1:0] val,
  input  logic root,
  output logic [p3d_pkg::OutW-1:0] res
);
  localparam int N = p3d_pkg::RootW;
  localparam int W = p3d_pkg::OutW;
  logic [W-1:0] rem [N+1];
  logic [N-1:0] q [N+1];
  logic [W-1:0] orig [N+1];
  logic rt [N+1];

  always_comb begin
    rem[0] = val;
    q[0] = '0;
    orig[0] = val;
    rt[0] = root;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    localparam int B = N - 1 - i;
    logic [W-1:0] trial;
    logic [N-1:0] qn;
    logic ge;
    always_comb begin
      qn = q[i] | (N'(1) << B);
      trial = W'({21'd0, qn} * {21'd0, qn});
      ge = trial <= orig[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q[i+1] <= ge ? qn : q[i];
        rem[i+1] <= rem[i];
        orig[i+1] <= orig[i];
        rt[i+1] <= rt[i];
      end
    end
  end

  assign res = rt[N] ? W'(q[N]) : rem[N];
endmodule

// ===== sv/p3d_merge.sv =====
// Merge stage: sums the three lane squares.
module p3d_merge (
  input  logic clk,
  input  logic en,
  input  logic [p3d_pkg::SqW-1:0] sx,
  input  logic [p3d_pkg::SqW-1:0] sy,
  input  logic [p3d_pkg::SqW-1:0] sz,
  output logic [p3d_pkg::OutW-1:0] sum
);
  always_ff @(posedge clk) begin
    if (en) sum <= sx + sy + sz;
  end
endmodule

// ===== sv/periodic_3d_distance.sv =====
// Top level: minimum-image 3D distance, three axis lanes, merge and root pipeline.
// Usage:
//   in_ch  : one point pair per transfer (first_x..second_z, signed Q12.8).
//   out_ch : one distance per transfer, squared Q.16 or root Q.8 (take_root).
//   cfg    : register writes (index, data); write only while the pipe is empty.
// Throughput: one pair per cycle while the pipe is not stalled by out_ch.
// Pipeline: two lane stages (abs diff, square), one merge adder stage
//   and 21 root stages, one per result bit, then the output register.
//   The mode travels with each item.
// The whole pipeline advances together; when out_ch stalls with valid
//   high and the last stage is full, every stage holds and in_ch.ready
//   drops. An empty last stage ahead of the output register lets it advance.
// Reset clears valid bits and loads register defaults (root on, no wrap).
module periodic_3d_distance (
  input logic clk,
  input logic rst,
  p3d_stream_if.sink in_ch,
  p3d_stream_if.source out_ch,
  p3d_stream_if.sink cfg
);
  localparam int Depth = 3 + p3d_pkg::RootW;
  logic [p3d_pkg::BoxW-1:0] box_width, box_height, box_depth;
  logic periodic_mode, take_root;
  logic [Depth-1:0] vld;
  logic en;
  logic en_out;
  logic rt [4];
  logic [p3d_pkg::SqW-1:0] sx, sy, sz;
  logic [p3d_pkg::OutW-1:0] sum, res;
  p3d_pkg::pair_t p;
  p3d_pkg::cfg_t c;

  assign p = in_ch.payload;
  assign c = cfg.payload;
  assign cfg.ready = 1'b1;
  assign en_out = !out_ch.valid || out_ch.ready;
  assign en = en_out || !vld[Depth-1];
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width <= '0;
      box_height <= '0;
      box_depth <= '0;
      periodic_mode <= 1'b0;
      take_root <= 1'b1;
    end else if (cfg.valid) begin
      unique case (c.index)
        p3d_pkg::RegBoxWidth: box_width <= c.data;
        p3d_pkg::RegBoxHeight: box_height <= c.data;
        p3d_pkg::RegBoxDepth: box_depth <= c.data;
        p3d_pkg::RegPeriodic: periodic_mode <= c.data[0];
        p3d_pkg::RegTakeRoot: take_root <= c.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Depth-2:0], in_ch.valid};
  end

  always_comb rt[0] = take_root;
  for (genvar i = 0; i < 3; i++) begin : g_rt
    always_ff @(posedge clk) if (en) rt[i+1] <= rt[i];
  end

  p3d_lane u_x (.clk, .en, .a(p.first_x), .b(p.second_x), .box(box_width),
    .periodic(periodic_mode), .sq(sx));
  p3d_lane u_y (.clk, .en, .a(p.first_y), .b(p.second_y), .box(box_height),
    .periodic(periodic_mode), .sq(sy));
  p3d_lane u_z (.clk, .en, .a(p.first_z), .b(p.second_z), .box(box_depth),
    .periodic(periodic_mode), .sq(sz));
  p3d_merge u_m (.clk, .en, .sx, .sy, .sz, .sum);
  p3d_sqrt u_s (.clk, .en, .val(sum), .root(rt[3]), .res);

  logic ov;
  logic [p3d_pkg::OutW-1:0] od;
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (en_out) ov <= vld[Depth-1];
  end
  always_ff @(posedge clk) if (en_out) od <= res;
  assign out_ch.valid = ov;
  assign out_ch.payload = od;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("ready low without stall");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("output valid after reset");
endmodule
